>>> rtl/wfs_pkg.sv
// Shared types, widths and codes for the wind and fire sequencer.
package wfs_pkg;

    localparam int POS_BITS   = 24;
    localparam int TGT_W      = POS_BITS + 1;
    localparam int CMP_W      = POS_BITS + 3;
    localparam int CFG_W      = 16;
    localparam int OFS_W      = 12;
    localparam int PAUSE_W    = 16;
    localparam int STUCK_W    = 17;
    localparam int CMD_W      = 2;
    localparam int CNT_W      = $clog2(POS_BITS);
    localparam int S_TDATA_W  = ((POS_BITS + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((TGT_W + PAUSE_W + 7) / 8) * 8;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;

    localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(POS_BITS - 1);
    localparam logic [STUCK_W-1:0] STUCK_MAX = '1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WINDING = 2'd1,
        PH_LOCKED  = 2'd2,
        PH_FIRING  = 2'd3
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_REV_PERIOD     = 3'd0,
        REG_PARK_OFFSET    = 3'd1,
        REG_LOCK_WINDOW    = 3'd2,
        REG_FIRE_TRAVEL    = 3'd3,
        REG_FIRE_WINDOW    = 3'd4,
        REG_STUCK_LIMIT    = 3'd5,
        REG_LOCK_PAUSE_MS  = 3'd6,
        REG_STUCK_PAUSE_MS = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]   rev_period;
        logic [OFS_W-1:0]   park_offset;
        logic [OFS_W-1:0]   lock_window;
        logic [CFG_W-1:0]   fire_travel;
        logic [CFG_W-1:0]   fire_window;
        logic [CFG_W-1:0]   stuck_limit;
        logic [PAUSE_W-1:0] lock_pause_ms;
        logic [PAUSE_W-1:0] stuck_pause_ms;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic zero_calc;
        logic decide;
        logic sel_second;
    } ctrl_cmd_t;

    typedef struct packed {
        logic two_items;
    } dp_stat_t;

    typedef struct packed {
        cmd_t                     command;
        logic signed [TGT_W-1:0]  target;
        logic [PAUSE_W-1:0]       pause_ms;
        logic                     last;
    } item_t;

endpackage

>>> rtl/wind_and_fire_sequencer.sv
// Top level of the wind and fire sequencer: register file, controller, datapath.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: toggle_press, position
//  m_      | out | m_tvalid/m_tready  | m_tdata: target, pause_ms; m_tuser: command; m_tlast
//  apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// From accept to its first result a tick runs the remainder iterations, a zero step and a
// decide step, the remainder unit retiring one position bit per cycle; results then go
// out one per cycle while m_tready is high.
// Reset is synchronous on aresetn and needs no clearing pass.
// One tick is in flight at a time; s_tready stays low until its last result is taken.
module wind_and_fire_sequencer import wfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] toggle_press, [POS_BITS:1] position
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // target, then pause_ms, zero filled
    output logic [CMD_W-1:0]     m_tuser,   // command
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    item_t     out_item;

    wfs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_toggle (s_tdata[0]),
        .in_pos    ($signed(s_tdata[POS_BITS:1])),
        .out_item  (out_item)
    );

    assign m_tdata = M_TDATA_W'({out_item.pause_ms, out_item.target});
    assign m_tuser = out_item.command;
    assign m_tlast = out_item.last;

endmodule

>>> rtl/wfs_cfg.sv
// APB register file holding the sequencer configuration.
module wfs_cfg import wfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rev_period     <= CFG_W'(1800);
            cfg_reg.park_offset    <= OFS_W'(5);
            cfg_reg.lock_window    <= OFS_W'(15);
            cfg_reg.fire_travel    <= CFG_W'(200);
            cfg_reg.fire_window    <= CFG_W'(190);
            cfg_reg.stuck_limit    <= CFG_W'(400);
            cfg_reg.lock_pause_ms  <= PAUSE_W'(1000);
            cfg_reg.stuck_pause_ms <= PAUSE_W'(2500);
        end else if (wr_en) begin
            unique case (idx)
                REG_REV_PERIOD:     cfg_reg.rev_period     <= pwdata[CFG_W-1:0];
                REG_PARK_OFFSET:    cfg_reg.park_offset    <= pwdata[OFS_W-1:0];
                REG_LOCK_WINDOW:    cfg_reg.lock_window    <= pwdata[OFS_W-1:0];
                REG_FIRE_TRAVEL:    cfg_reg.fire_travel    <= pwdata[CFG_W-1:0];
                REG_FIRE_WINDOW:    cfg_reg.fire_window    <= pwdata[CFG_W-1:0];
                REG_STUCK_LIMIT:    cfg_reg.stuck_limit    <= pwdata[CFG_W-1:0];
                REG_LOCK_PAUSE_MS:  cfg_reg.lock_pause_ms  <= pwdata[PAUSE_W-1:0];
                REG_STUCK_PAUSE_MS: cfg_reg.stuck_pause_ms <= pwdata[PAUSE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_REV_PERIOD:     prdata = APB_W'(cfg_reg.rev_period);
            REG_PARK_OFFSET:    prdata = APB_W'(cfg_reg.park_offset);
            REG_LOCK_WINDOW:    prdata = APB_W'(cfg_reg.lock_window);
            REG_FIRE_TRAVEL:    prdata = APB_W'(cfg_reg.fire_travel);
            REG_FIRE_WINDOW:    prdata = APB_W'(cfg_reg.fire_window);
            REG_STUCK_LIMIT:    prdata = APB_W'(cfg_reg.stuck_limit);
            REG_LOCK_PAUSE_MS:  prdata = APB_W'(cfg_reg.lock_pause_ms);
            REG_STUCK_PAUSE_MS: prdata = APB_W'(cfg_reg.stuck_pause_ms);
        endcase
    end

endmodule

>>> rtl/wfs_ctrl.sv
// Controller state machine: accept, remainder iterations, zero step, decide, result delivery.
module wfs_ctrl import wfs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_READY,
        ST_DIV,
        ST_ZERO,
        ST_DECIDE,
        ST_SEND0,
        ST_SEND1
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              s_tready_reg;
    logic              m_tvalid_reg;
    logic              sel_reg;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.load       = (state_reg == ST_READY) && s_tvalid;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.zero_calc  = (state_reg == ST_ZERO);
        cmd.decide     = (state_reg == ST_DECIDE);
        cmd.sel_second = sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_READY;
            cnt_reg      <= '0;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            sel_reg      <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_READY: begin
                    if (s_tvalid) begin
                        state_reg    <= ST_DIV;
                        cnt_reg      <= DIV_LAST;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_ZERO;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_ZERO: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    state_reg    <= ST_SEND0;
                    m_tvalid_reg <= 1'b1;
                    sel_reg      <= 1'b0;
                end
                ST_SEND0: begin
                    if (m_tready) begin
                        if (stat.two_items) begin
                            state_reg <= ST_SEND1;
                            sel_reg   <= 1'b1;
                        end else begin
                            state_reg    <= ST_READY;
                            m_tvalid_reg <= 1'b0;
                            s_tready_reg <= 1'b1;
                        end
                    end
                end
                ST_SEND1: begin
                    if (m_tready) begin
                        state_reg    <= ST_READY;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                        sel_reg      <= 1'b0;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/wfs_dp.sv
// Datapath: bit-serial remainder, phase state, result item registers.
module wfs_dp import wfs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  ctrl_cmd_t                cmd,
    output dp_stat_t                 stat,
    input  logic                     in_toggle,
    input  logic signed [POS_BITS-1:0] in_pos,
    output item_t                    out_item
);

    // captured request
    logic                      toggle_reg;
    logic signed [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0]       mag_reg;
    logic [CFG_W-1:0]          rem_reg;
    logic signed [TGT_W-1:0]   nzc_reg;

    // architectural state
    logic                      engaged_reg;
    phase_t                    phase_reg;
    logic signed [TGT_W-1:0]   nz_reg;
    logic [STUCK_W-1:0]        stuck_reg;

    item_t                     item0_reg;
    item_t                     item1_reg;
    logic                      two_reg;

    logic [CFG_W-1:0]          per;
    logic [CFG_W:0]            trial;
    logic                      trial_ge;
    logic [CFG_W-1:0]          rem_next;
    logic signed [TGT_W-1:0]   pos_x;
    logic signed [TGT_W-1:0]   per_x;
    logic signed [TGT_W-1:0]   rem_x;
    logic signed [TGT_W-1:0]   nzc_next;

    logic signed [CMP_W-1:0]   pos_w;
    logic signed [CMP_W-1:0]   nzc_w;
    logic signed [CMP_W-1:0]   nz_w;
    logic                      lock_hit;
    logic                      fire_done;
    logic signed [TGT_W-1:0]   wind_tgt;
    logic signed [TGT_W-1:0]   fire_tgt;
    logic [STUCK_W-1:0]        stuck_inc;
    logic                      wind_abort;
    logic                      fire_abort;

    logic                      engaged_next;
    phase_t                    phase_next;
    logic signed [TGT_W-1:0]   nz_next;
    logic [STUCK_W-1:0]        stuck_next;
    item_t                     item0_next;
    item_t                     item1_next;
    logic                      two_next;

    // a zero period rounds like a period of one
    assign per      = (cfg.rev_period == '0) ? CFG_W'(1) : cfg.rev_period;
    assign trial    = {rem_reg, mag_reg[POS_BITS-1]};
    assign trial_ge = trial >= {1'b0, per};
    assign rem_next = trial_ge ? CFG_W'(trial - {1'b0, per}) : trial[CFG_W-1:0];

    // truncated remainder carries the sign of the position
    assign pos_x    = TGT_W'(pos_reg);
    assign per_x    = $signed(TGT_W'(per));
    assign rem_x    = $signed(TGT_W'(rem_reg));
    assign nzc_next = (rem_reg == '0) ? pos_x :
                      pos_reg[POS_BITS-1] ? pos_x + per_x + rem_x : pos_x + per_x - rem_x;

    assign pos_w     = CMP_W'(pos_reg);
    assign nzc_w     = CMP_W'(nzc_reg);
    assign nz_w      = CMP_W'(nz_reg);
    assign lock_hit  = pos_w > (nzc_w - $signed(CMP_W'(cfg.lock_window)));
    assign fire_done = pos_w > (nz_w + $signed(CMP_W'(cfg.fire_window)));
    assign wind_tgt  = TGT_W'(nzc_w - $signed(CMP_W'(cfg.park_offset)));
    assign fire_tgt  = TGT_W'(nz_w + $signed(CMP_W'(cfg.fire_travel)));
    assign stuck_inc = (stuck_reg == STUCK_MAX) ? stuck_reg : stuck_reg + 1'b1;
    assign wind_abort = stuck_inc >  STUCK_W'(cfg.stuck_limit);
    assign fire_abort = stuck_inc >= STUCK_W'(cfg.stuck_limit);

    always_comb begin
        engaged_next = engaged_reg ^ toggle_reg;
        phase_next   = phase_reg;
        nz_next      = nz_reg;
        stuck_next   = stuck_reg;
        two_next     = 1'b0;
        item0_next   = '{command: CMD_NONE, target: '0, pause_ms: '0, last: 1'b1};
        item1_next   = '{command: CMD_NONE, target: '0, pause_ms: '0, last: 1'b1};
        if (!engaged_next) begin
            phase_next         = PH_IDLE;
            item0_next.command = CMD_STOP;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_WINDING;
                    stuck_next = '0;
                end
                PH_WINDING: begin
                    stuck_next = stuck_inc;
                    nz_next    = nzc_reg;
                    if (wind_abort) begin
                        // stop first, then the move
                        two_next            = 1'b1;
                        item0_next.command  = CMD_STOP;
                        item0_next.pause_ms = cfg.stuck_pause_ms;
                        item0_next.last     = 1'b0;
                        item1_next.command  = CMD_MOVE;
                        item1_next.target   = wind_tgt;
                    end else begin
                        item0_next.command  = CMD_MOVE;
                        item0_next.target   = wind_tgt;
                    end
                    // locking overrides a stuck abort
                    if (lock_hit) begin
                        phase_next = PH_LOCKED;
                    end else if (wind_abort) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LOCKED: begin
                    stuck_next          = '0;
                    phase_next          = PH_FIRING;
                    item0_next.pause_ms = cfg.lock_pause_ms;
                end
                PH_FIRING: begin
                    stuck_next         = stuck_inc;
                    item0_next.command = CMD_MOVE;
                    item0_next.target  = fire_tgt;
                    if (fire_abort) begin
                        phase_next          = PH_IDLE;
                        two_next            = 1'b1;
                        item0_next.last     = 1'b0;
                        item1_next.command  = CMD_STOP;
                        item1_next.pause_ms = cfg.stuck_pause_ms;
                    end else if (fire_done) begin
                        phase_next = PH_WINDING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            toggle_reg <= in_toggle;
            pos_reg    <= in_pos;
            mag_reg    <= in_pos[POS_BITS-1] ? POS_BITS'(-in_pos) : in_pos;
            rem_reg    <= '0;
        end else if (cmd.div_step) begin
            mag_reg <= {mag_reg[POS_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.zero_calc) begin
            nzc_reg <= nzc_next;
        end
        if (cmd.decide) begin
            item0_reg <= item0_next;
            item1_reg <= item1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engaged_reg <= 1'b0;
            phase_reg   <= PH_LOCKED;
            nz_reg      <= '0;
            stuck_reg   <= '0;
            two_reg     <= 1'b0;
        end else if (cmd.decide) begin
            engaged_reg <= engaged_next;
            phase_reg   <= phase_next;
            nz_reg      <= nz_next;
            stuck_reg   <= stuck_next;
            two_reg     <= two_next;
        end
    end

    assign stat.two_items = two_reg;
    assign out_item       = cmd.sel_second ? item1_reg : item0_reg;

endmodule

>>> rtl/wfs_checker.sv
// Port-level checks for the wind and fire sequencer, bound to the top level.
module wfs_checker import wfs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [CMD_W-1:0]     m_tuser,
    input logic                 m_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while results pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("not busy after request");

    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second result missing");

    a_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CMD_MOVE |-> m_tdata[TGT_W-1:0] == '0)
        else $error("target set on non-move result");

endmodule

bind wind_and_fire_sequencer wfs_checker u_wfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
